// ===== hdl/mfts_pkg.sv =====
// Shared types and constants of the multilevel feedback task scheduler.
// No dependencies.
package mfts_pkg;

  localparam int KIND_W       = 3;
  localparam int TASK_ID_W    = 4;
  localparam int LANE_OUT_W   = 2;
  localparam int CREDIT_OUT_W = 8;
  localparam int READY_W      = 5;
  localparam int SWITCH_W     = 32;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 8;
  localparam int QUANT_REGS   = 4;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD      = 3'd0,
    KIND_REMOVE   = 3'd1,
    KIND_YIELD    = 3'd2,
    KIND_SCHEDULE = 3'd3,
    KIND_TICK     = 3'd4,
    KIND_EXIT     = 3'd5,
    KIND_JOIN     = 3'd6,
    KIND_LEAVE    = 3'd7
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PREEMPT = 3'd0,
    CFG_QUANT0  = 3'd1,
    CFG_QUANT1  = 3'd2,
    CFG_QUANT2  = 3'd3,
    CFG_QUANT3  = 3'd4
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_EXEC = 2'b10
  } state_e;

  typedef logic [CFG_DATA_W-1:0] quant_arr_t [QUANT_REGS];

  localparam quant_arr_t QUANT_RESET = '{8'd2, 8'd4, 8'd8, 8'd16};

endpackage

// ===== hdl/mfts_if.sv =====
// Request and response channels of the task scheduler.
// Depends on mfts_pkg.
interface mfts_req_if;
  logic                             valid;
  logic                             ready;
  logic [mfts_pkg::KIND_W-1:0]      kind;
  logic [mfts_pkg::TASK_ID_W-1:0]   task_id;

  modport source (output valid, kind, task_id, input ready);
  modport sink   (input valid, kind, task_id, output ready);
endinterface

interface mfts_rsp_if;
  logic                               valid;
  logic                               ready;
  logic                               switched;
  logic [mfts_pkg::TASK_ID_W-1:0]     running_task;
  logic [mfts_pkg::LANE_OUT_W-1:0]    running_lane;
  logic [mfts_pkg::CREDIT_OUT_W-1:0]  running_credit;
  logic [mfts_pkg::READY_W-1:0]       ready_total;
  logic [mfts_pkg::SWITCH_W-1:0]      switch_total;
  logic                               status;

  modport source (output valid, switched, running_task, running_lane, running_credit,
                  ready_total, switch_total, status, input ready);
  modport sink   (input valid, switched, running_task, running_lane, running_credit,
                  ready_total, switch_total, status, output ready);
endinterface

// ===== hdl/mfts_link_mem.sv =====
// Link memories of the lane lists: next and previous task per entry.
// One read address, one write port per memory, registered read data.
module mfts_link_mem #(
  parameter int MAX_TASKS = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rd_en_i,
  input  logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] rd_addr_i,
  output logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] rd_next_o,
  output logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] rd_prev_o,
  input  logic                                        next_we_i,
  input  logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] next_addr_i,
  input  logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] next_data_i,
  input  logic                                        prev_we_i,
  input  logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] prev_addr_i,
  input  logic [((MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1)-1:0] prev_data_i
);
  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;

  logic [IW-1:0] next_mem [MAX_TASKS];
  logic [IW-1:0] prev_mem [MAX_TASKS];

  always_ff @(posedge clk_i) begin
    if (next_we_i) begin
      next_mem[next_addr_i] <= next_data_i;
    end
    if (prev_we_i) begin
      prev_mem[prev_addr_i] <= prev_data_i;
    end
    if (rd_en_i) begin
      rd_next_o <= next_mem[rd_addr_i];
      rd_prev_o <= prev_mem[rd_addr_i];
    end
  end
endmodule

// ===== hdl/multilevel_feedback_task_scheduler.sv =====
// Multilevel feedback task scheduler: lane lists, task flags, dispatch.
// Depends on mfts_pkg, mfts_if and mfts_link_mem.
// Operation: a request is accepted in idle, then an execute step uses the link
// memory read issued at acceptance (one read-modify-write pass) and may stall
// while an earlier response is not taken; a new request is taken only after it ends.
// Reset: async, active low; lanes empty, idle task 0 running with lane-0 credit.
module multilevel_feedback_task_scheduler #(
  parameter int NUM_LANES   = 4,
  parameter int MAX_TASKS   = 16,
  parameter int CREDIT_BITS = 8
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mfts_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mfts_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  mfts_req_if.sink                         req_i,
  mfts_rsp_if.source                       rsp_o
);
  import mfts_pkg::*;

  localparam int IW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int LW = $clog2(NUM_LANES);
  localparam int CW = $clog2(MAX_TASKS + 1);

  typedef logic [IW-1:0]          tid_t;
  typedef logic [LW-1:0]          lane_t;
  typedef logic [CREDIT_BITS-1:0] cred_t;

  state_e  state_q, state_d;
  kind_e   kind_q;
  logic [TASK_ID_W-1:0] tid_q;

  tid_t    head_q [NUM_LANES];
  tid_t    head_d [NUM_LANES];
  tid_t    tail_q [NUM_LANES];
  tid_t    tail_d [NUM_LANES];
  logic [NUM_LANES-1:0] ne_q, ne_d;
  lane_t   lane_q [MAX_TASKS];
  lane_t   lane_d [MAX_TASKS];
  logic [MAX_TASKS-1:0] part_q, part_d, queued_q, queued_d;
  tid_t    running_q, running_d;
  lane_t   run_lane_q, run_lane_d;
  cred_t   credit_q, credit_d;
  logic [CW-1:0]       cnt_q, cnt_d;
  logic [SWITCH_W-1:0] swcnt_q, swcnt_d;

  logic                  armed_q;
  logic [CFG_DATA_W-1:0] quant_q [QUANT_REGS];

  logic out_v_q;
  logic sw_q, st_q, sw_d, st_d;

  logic accept, go;
  logic found;
  tid_t pick_id;
  tid_t rd_next, rd_prev;
  logic next_we, prev_we;
  tid_t next_addr, next_data, prev_addr, prev_data;

  function automatic cred_t quant(lane_t l);
    logic [CFG_DATA_W-1:0] q;
    q = quant_q[QUANT_REGS-1];
    for (int i = 0; i < QUANT_REGS - 1; i++) begin
      if (int'(l) == i) q = quant_q[i];
    end
    return CREDIT_BITS'(q);
  endfunction

  assign accept      = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);
  assign go          = (state_q == ST_EXEC) && (!out_v_q || rsp_o.ready);

  always_comb begin
    found   = 1'b0;
    pick_id = '0;
    for (int l = NUM_LANES - 1; l >= 0; l--) begin
      if (ne_q[l]) begin
        found   = 1'b1;
        pick_id = head_q[l];
      end
    end
  end

  mfts_link_mem #(.MAX_TASKS(MAX_TASKS)) u_link_mem (
    .clk_i       (clk_i),
    .rd_en_i     (accept),
    .rd_addr_i   ((kind_e'(req_i.kind) == KIND_REMOVE) ? IW'(req_i.task_id) : pick_id),
    .rd_next_o   (rd_next),
    .rd_prev_o   (rd_prev),
    .next_we_i   (next_we),
    .next_addr_i (next_addr),
    .next_data_i (next_data),
    .prev_we_i   (prev_we),
    .prev_addr_i (prev_addr),
    .prev_data_i (prev_data)
  );

  always_comb begin
    tid_t  tix, cur, ul_id, enq_id;
    logic  tvalid, ul_en, enq_en, do_rot, do_exit, rot_vol;
    lane_t l;
    cred_t c;

    head_d    = head_q;
    tail_d    = tail_q;
    ne_d      = ne_q;
    lane_d    = lane_q;
    part_d    = part_q;
    queued_d  = queued_q;
    running_d = running_q;
    run_lane_d = run_lane_q;
    credit_d  = credit_q;
    cnt_d     = cnt_q;
    swcnt_d   = swcnt_q;
    sw_d      = 1'b0;
    st_d      = 1'b0;
    next_we   = 1'b0;
    prev_we   = 1'b0;
    next_addr = '0;
    next_data = '0;
    prev_addr = '0;
    prev_data = '0;

    tix     = IW'(tid_q);
    tvalid  = int'(tid_q) < MAX_TASKS;
    cur     = running_q;
    ul_en   = 1'b0;
    ul_id   = pick_id;
    enq_en  = 1'b0;
    enq_id  = cur;
    do_rot  = 1'b0;
    do_exit = 1'b0;
    rot_vol = 1'b0;
    l       = '0;
    c       = credit_q;

    case (kind_q)
      KIND_ADD: begin
        if (!tvalid || tid_q == '0 || queued_q[tix] || tix == running_q) begin
          st_d = 1'b1;
        end else begin
          lane_d[tix] = '0;
          part_d[tix] = 1'b1;
          enq_en      = 1'b1;
          enq_id      = tix;
        end
      end
      KIND_REMOVE: begin
        if (tvalid) begin
          ul_en       = queued_q[tix];
          ul_id       = tix;
          part_d[tix] = 1'b0;
        end
      end
      KIND_YIELD: begin
        do_rot  = 1'b1;
        rot_vol = 1'b1;
      end
      KIND_SCHEDULE: do_rot = 1'b1;
      KIND_TICK: begin
        if (running_q != '0) begin
          c        = (credit_q != '0) ? credit_q - 1'b1 : credit_q;
          credit_d = c;
          do_rot   = (c == '0) && armed_q;
        end
      end
      KIND_EXIT: do_exit = 1'b1;
      KIND_JOIN: part_d[running_q] = 1'b1;
      default:   part_d[running_q] = 1'b0;
    endcase

    if ((do_rot || do_exit) && found) begin
      ul_en = 1'b1;
      ul_id = pick_id;
      if (do_rot && part_q[cur] && !queued_q[cur]) begin
        if (rot_vol) begin
          if (lane_q[cur] != '0) lane_d[cur] = lane_q[cur] - 1'b1;
        end else begin
          if (int'(lane_q[cur]) < NUM_LANES - 1) lane_d[cur] = lane_q[cur] + 1'b1;
        end
        enq_en = 1'b1;
        enq_id = cur;
      end
    end

    if (ul_en) begin
      l = lane_q[ul_id];
      if (head_q[l] == ul_id && tail_q[l] == ul_id) begin
        ne_d[l] = 1'b0;
      end else if (head_q[l] == ul_id) begin
        head_d[l] = rd_next;
      end else if (tail_q[l] == ul_id) begin
        tail_d[l] = rd_prev;
      end else begin
        next_we   = 1'b1;
        next_addr = rd_prev;
        next_data = rd_next;
        prev_we   = 1'b1;
        prev_addr = rd_next;
        prev_data = rd_prev;
      end
      queued_d[ul_id] = 1'b0;
      if (cnt_d != '0) cnt_d = cnt_d - 1'b1;
    end

    if (enq_en) begin
      l = lane_d[enq_id];
      if (ne_d[l]) begin
        next_we   = 1'b1;
        next_addr = tail_d[l];
        next_data = enq_id;
        prev_we   = 1'b1;
        prev_addr = enq_id;
        prev_data = tail_d[l];
      end else begin
        head_d[l] = enq_id;
        ne_d[l]   = 1'b1;
      end
      tail_d[l]        = enq_id;
      queued_d[enq_id] = 1'b1;
      cnt_d            = cnt_d + 1'b1;
    end

    if ((do_rot || do_exit) && found) begin
      credit_d   = quant(lane_q[pick_id]);
      run_lane_d = lane_q[pick_id];
      if (pick_id != running_q) begin
        running_d = pick_id;
        sw_d      = 1'b1;
        swcnt_d   = swcnt_q + 1'b1;
      end
    end

    if (!go) begin
      next_we = 1'b0;
      prev_we = 1'b0;
    end

    state_d = state_q;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_EXEC;
      ST_EXEC: if (go) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= kind_e'(req_i.kind);
      tid_q  <= req_i.task_id;
    end
    if (go) begin
      head_q <= head_d;
      tail_q <= tail_d;
      sw_q   <= sw_d;
      st_q   <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      ne_q       <= '0;
      part_q     <= '0;
      queued_q   <= '0;
      running_q  <= '0;
      run_lane_q <= '0;
      credit_q   <= CREDIT_BITS'(QUANT_RESET[0]);
      cnt_q      <= '0;
      swcnt_q    <= '0;
      out_v_q    <= 1'b0;
      for (int i = 0; i < MAX_TASKS; i++) begin
        lane_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (go) begin
        ne_q       <= ne_d;
        part_q     <= part_d;
        queued_q   <= queued_d;
        lane_q     <= lane_d;
        running_q  <= running_d;
        run_lane_q <= run_lane_d;
        credit_q   <= credit_d;
        cnt_q      <= cnt_d;
        swcnt_q    <= swcnt_d;
        out_v_q    <= 1'b1;
      end else if (rsp_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q <= 1'b0;
      quant_q <= QUANT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PREEMPT: armed_q    <= cfg_wdata_i[0];
        CFG_QUANT0:  quant_q[0] <= cfg_wdata_i;
        CFG_QUANT1:  quant_q[1] <= cfg_wdata_i;
        CFG_QUANT2:  quant_q[2] <= cfg_wdata_i;
        CFG_QUANT3:  quant_q[3] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign rsp_o.valid          = out_v_q;
  assign rsp_o.switched       = sw_q;
  assign rsp_o.status         = st_q;
  assign rsp_o.running_task   = TASK_ID_W'(running_q);
  assign rsp_o.running_lane   = LANE_OUT_W'(run_lane_q);
  assign rsp_o.running_credit = CREDIT_OUT_W'(credit_q);
  assign rsp_o.ready_total    = READY_W'(cnt_q);
  assign rsp_o.switch_total   = swcnt_q;

  a_count_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(cnt_q) == $countones(queued_q))
    else $error("ready count disagrees with queued flags");

  a_running_not_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !queued_q[running_q])
    else $error("running task is parked in a lane");

  a_write_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (next_we || prev_we) |-> go)
    else $error("link write outside execute step");

  a_switch_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && sw_d) |=> (swcnt_q == $past(swcnt_q) + 1'b1))
    else $error("switch not counted");
endmodule

// ===== sim/multilevel_feedback_task_scheduler_tb.sv =====
// Testbench of the multilevel feedback task scheduler: a directed table and random
// request phases under several register settings, checked against a behavioral predictor.
// Depends on mfts_pkg, mfts_if and the multilevel_feedback_task_scheduler RTL.
module multilevel_feedback_task_scheduler_tb;
  import mfts_pkg::*;

  typedef struct packed {
    logic        switched;
    logic [3:0]  run_id;
    logic [1:0]  lane;
    logic [7:0]  credit;
    logic [4:0]  ready_total;
    logic [31:0] switch_total;
    logic        status;
  } sched_result_t;

  typedef struct packed {
    kind_e         kind;
    logic [3:0]    id;
    logic          known;
    sched_result_t exp;
  } dir_row_t;

  localparam int NUM_DIR   = 22;
  localparam int PHASE_LEN = 290;
  localparam int LIMIT     = 600000;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;

  mfts_req_if req ();
  mfts_rsp_if rsp ();

  multilevel_feedback_task_scheduler DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req),
    .rsp_o       (rsp)
  );

  // scheduler state as predicted
  logic [3:0]  lane_first [4];
  logic [3:0]  lane_last [4];
  bit          lane_used [4];
  logic [3:0]  next_in_lane [16];
  logic [3:0]  prev_in_lane [16];
  logic [1:0]  task_lvl [16];
  logic [7:0]  task_cred [16];
  bit          task_member [16];
  bit          task_parked [16];
  logic [3:0]  cur_task;
  logic [4:0]  parked_cnt;
  logic [31:0] switch_cnt;
  bit          preempt_on;
  logic [7:0]  quantum [4];

  sched_result_t pending_results[$];
  int  errors;
  bit  no_gaps;
  bit  hold_rsp;
  int  cycles;

  function automatic void park_task(input logic [3:0] t);
    logic [1:0] l;
    l = task_lvl[t];
    if (lane_used[l]) begin
      next_in_lane[lane_last[l]] = t;
      prev_in_lane[t] = lane_last[l];
    end else begin
      lane_first[l] = t;
      lane_used[l] = 1;
    end
    lane_last[l] = t;
    task_parked[t] = 1;
    parked_cnt++;
  endfunction

  function automatic void unpark_task(input logic [3:0] t);
    logic [1:0] l;
    l = task_lvl[t];
    if (lane_first[l] == t && lane_last[l] == t) begin
      lane_used[l] = 0;
    end else if (lane_first[l] == t) begin
      lane_first[l] = next_in_lane[t];
    end else if (lane_last[l] == t) begin
      lane_last[l] = prev_in_lane[t];
    end else begin
      next_in_lane[prev_in_lane[t]] = next_in_lane[t];
      prev_in_lane[next_in_lane[t]] = prev_in_lane[t];
    end
    task_parked[t] = 0;
    if (parked_cnt > 0) parked_cnt--;
  endfunction

  function automatic bit pick_task(output logic [3:0] t);
    t = '0;
    for (int l = 0; l < 4; l++) begin
      if (lane_used[l]) begin
        t = lane_first[l];
        return 1;
      end
    end
    return 0;
  endfunction

  function automatic bit run_task(input logic [3:0] t);
    task_cred[t] = quantum[task_lvl[t]];
    if (t == cur_task) return 0;
    cur_task = t;
    switch_cnt++;
    return 1;
  endfunction

  function automatic bit rotate_task(input bit voluntary);
    logic [3:0] nxt, cur;
    cur = cur_task;
    if (!pick_task(nxt)) return 0;
    unpark_task(nxt);
    if (task_member[cur] && !task_parked[cur]) begin
      if (voluntary) begin
        if (task_lvl[cur] > 0) task_lvl[cur]--;
      end else if (task_lvl[cur] < 3) begin
        task_lvl[cur]++;
      end
      task_cred[cur] = quantum[task_lvl[cur]];
      park_task(cur);
    end
    return run_task(nxt);
  endfunction

  function automatic sched_result_t predict_request(input kind_e kind, input logic [3:0] t);
    sched_result_t r;
    logic [3:0] nxt;
    r = '0;
    case (kind)
      KIND_ADD: begin
        if (t == 0 || task_parked[t] || t == cur_task) begin
          r.status = 1;
        end else begin
          task_lvl[t] = 0;
          task_cred[t] = quantum[0];
          task_member[t] = 1;
          park_task(t);
        end
      end
      KIND_REMOVE: begin
        if (task_parked[t]) unpark_task(t);
        task_member[t] = 0;
      end
      KIND_YIELD:    r.switched = rotate_task(1);
      KIND_SCHEDULE: r.switched = rotate_task(0);
      KIND_TICK: begin
        if (cur_task != 0) begin
          if (task_cred[cur_task] > 0) task_cred[cur_task]--;
          if (task_cred[cur_task] == 0 && preempt_on) r.switched = rotate_task(0);
        end
      end
      KIND_EXIT: begin
        if (pick_task(nxt)) begin
          unpark_task(nxt);
          r.switched = run_task(nxt);
        end
      end
      KIND_JOIN: task_member[cur_task] = 1;
      default:   task_member[cur_task] = 0;
    endcase
    r.run_id = cur_task;
    r.lane = task_lvl[cur_task];
    r.credit = task_cred[cur_task];
    r.ready_total = parked_cnt;
    r.switch_total = switch_cnt;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
    if (e !== a) begin
      $display("%0t: %s expected %0d got %0d", $time, name, e, a);
      errors++;
    end
  endtask

  task automatic send_request(input kind_e kind, input logic [3:0] id, input bit known,
                              input sched_result_t exp);
    int gap;
    sched_result_t r;
    gap = no_gaps ? 0 : ($urandom_range(0, 9) < 6 ? 0 :
                         ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3)
                                                   : $urandom_range(10, 40)));
    if (gap > 0) begin
      req.valid <= 0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1;
    req.kind <= kind;
    req.task_id <= id;
    forever begin
      @(posedge clk_i);
      if (req.ready) break;
    end
    r = predict_request(kind, id);
    pending_results.push_back(known ? exp : r);
  endtask

  task automatic write_config(input bit pre, input logic [7:0] q0, input logic [7:0] q1,
                              input logic [7:0] q2, input logic [7:0] q3);
    logic [7:0] vals [5];
    req.valid <= 0;
    wait (pending_results.size() == 0);
    repeat (6) @(posedge clk_i);
    vals = '{{7'd0, pre}, q0, q1, q2, q3};
    for (int i = 0; i < 5; i++) begin
      cfg_we_i <= 1;
      cfg_idx_i <= cfg_idx_e'(i);
      cfg_wdata_i <= vals[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 0;
    preempt_on = pre;
    quantum = '{q0, q1, q2, q3};
  endtask

  task automatic random_phase(input int n);
    int p;
    kind_e k;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < 30)      k = KIND_ADD;
      else if (p < 55) k = KIND_TICK;
      else if (p < 65) k = KIND_YIELD;
      else if (p < 75) k = KIND_SCHEDULE;
      else if (p < 82) k = KIND_EXIT;
      else if (p < 88) k = KIND_JOIN;
      else if (p < 93) k = KIND_LEAVE;
      else             k = KIND_REMOVE;
      send_request(k, 4'($urandom_range(0, 15)), 0, '0);
    end
  endtask

  dir_row_t dir_rows [NUM_DIR];

  initial begin
    clk_i = 0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > LIMIT) begin
        $display("multilevel_feedback_task_scheduler_tb NOT OK");
        $finish;
      end
    end
  end

  // response side: checks each response; random stalls, one long hold on request, always ready without gaps
  initial begin
    int stall;
    rsp.ready = 0;
    forever begin
      @(posedge clk_i);
      if (rsp.valid && rsp.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: response with nothing expected", $time);
          errors++;
        end else begin
          sched_result_t e;
          e = pending_results.pop_front();
          check_field("switched", e.switched, rsp.switched);
          check_field("running_task", e.run_id, rsp.running_task);
          check_field("running_lane", e.lane, rsp.running_lane);
          check_field("running_credit", e.credit, rsp.running_credit);
          check_field("ready_total", e.ready_total, rsp.ready_total);
          check_field("switch_total", e.switch_total, rsp.switch_total);
          check_field("status", e.status, rsp.status);
        end
      end
      if (hold_rsp) begin
        rsp.ready <= 0;
        repeat (300) @(posedge clk_i);
        hold_rsp = 0;
        rsp.ready <= 1;
      end else if (no_gaps) begin
        rsp.ready <= 1;
      end else begin
        stall = $urandom_range(0, 9) < 7 ? 0 :
                ($urandom_range(0, 9) < 8 ? $urandom_range(1, 3) : $urandom_range(10, 40));
        if (stall > 0) begin
          rsp.ready <= 0;
          repeat (stall) @(posedge clk_i);
        end
        rsp.ready <= 1;
      end
    end
  end

  initial begin
    errors = 0;
    no_gaps = 0;
    hold_rsp = 0;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_idx_i = CFG_PREEMPT;
    cfg_wdata_i = '0;
    req.valid = 0;
    req.kind = KIND_ADD;
    req.task_id = '0;

    for (int i = 0; i < 4; i++) begin
      lane_first[i] = '0;
      lane_last[i] = '0;
      lane_used[i] = 0;
      quantum[i] = QUANT_RESET[i];
    end
    for (int i = 0; i < 16; i++) begin
      next_in_lane[i] = '0;
      prev_in_lane[i] = '0;
      task_lvl[i] = '0;
      task_cred[i] = '0;
      task_member[i] = 0;
      task_parked[i] = 0;
    end
    task_cred[0] = quantum[0];
    cur_task = '0;
    parked_cnt = '0;
    switch_cnt = '0;
    preempt_on = 0;

    dir_rows = '{
      '{KIND_TICK,     4'd0,  1'b1, '{1'b0, 4'd0, 2'd0, 8'd2, 5'd0, 32'd0, 1'b0}},
      '{KIND_ADD,      4'd0,  1'b1, '{1'b0, 4'd0, 2'd0, 8'd2, 5'd0, 32'd0, 1'b1}},
      '{KIND_ADD,      4'd15, 1'b1, '{1'b0, 4'd0, 2'd0, 8'd2, 5'd1, 32'd0, 1'b0}},
      '{KIND_ADD,      4'd1,  1'b0, '0},
      '{KIND_ADD,      4'd1,  1'b0, '0},
      '{KIND_YIELD,    4'd0,  1'b0, '0},
      '{KIND_ADD,      4'd15, 1'b0, '0},
      '{KIND_TICK,     4'd0,  1'b0, '0},
      '{KIND_TICK,     4'd0,  1'b0, '0},
      '{KIND_JOIN,     4'd0,  1'b0, '0},
      '{KIND_SCHEDULE, 4'd0,  1'b0, '0},
      '{KIND_TICK,     4'd0,  1'b0, '0},
      '{KIND_EXIT,     4'd0,  1'b0, '0},
      '{KIND_LEAVE,    4'd0,  1'b0, '0},
      '{KIND_REMOVE,   4'd1,  1'b0, '0},
      '{KIND_YIELD,    4'd0,  1'b0, '0},
      '{KIND_ADD,      4'd8,  1'b0, '0},
      '{KIND_REMOVE,   4'd8,  1'b0, '0},
      '{KIND_REMOVE,   4'd0,  1'b0, '0},
      '{KIND_ADD,      4'd9,  1'b0, '0},
      '{KIND_YIELD,    4'd7,  1'b0, '0},
      '{KIND_TICK,     4'd6,  1'b0, '0}
    };

    repeat (5) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    foreach (dir_rows[i])
      send_request(dir_rows[i].kind, dir_rows[i].id, dir_rows[i].known, dir_rows[i].exp);
    random_phase(PHASE_LEN);

    write_config(1, 8'd2, 8'd4, 8'd8, 8'd16);
    hold_rsp = 1;
    random_phase(PHASE_LEN);
    write_config(1, 8'd0, 8'd0, 8'd0, 8'd0);
    no_gaps = 1;
    random_phase(PHASE_LEN);
    no_gaps = 0;
    write_config(1, 8'd255, 8'd255, 8'd255, 8'd255);
    random_phase(PHASE_LEN);
    write_config(0, 8'd1, 8'd3, 8'd5, 8'd255);
    random_phase(PHASE_LEN);
    write_config(1, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    random_phase(PHASE_LEN);
    write_config(1, 8'd1, 8'd1, 8'd1, 8'd1);
    random_phase(80);

    req.valid <= 0;
    wait (pending_results.size() == 0);
    repeat (10) @(posedge clk_i);
    if (errors == 0) begin
      $display("multilevel_feedback_task_scheduler_tb OK");
    end else begin
      $display("multilevel_feedback_task_scheduler_tb NOT OK");
    end
    $finish;
  end

endmodule
